FILE: sv/imufrp_pkg.sv
// Shared types and constants of the IMU frame receiver and publisher.
package imufrp_pkg;

    // Frame layout
    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [3:0] FRAME_LAST = 4'd10;   // position of the checksum byte
    localparam int         PAYLOAD_LEN = 6;

    // Axis scaling: raw * scale / 32768, truncated toward zero
    localparam int SCALE_SHIFT = 15;
    localparam int PROD_W      = 28;
    localparam logic signed [PROD_W-1:0] GYRO_SCALE  = 28'sd2000;
    localparam logic signed [PROD_W-1:0] ANGLE_SCALE = 28'sd180;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS  = 28'sd32767;

    // Field widths
    localparam int GYRO_W  = 12;
    localparam int ANGLE_W = 9;
    localparam int CFG_W   = 16;
    localparam int COUNT_W = 16;

    // Input word kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Register indexes
    localparam logic [1:0] REG_STALE_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_PUBLISH_PERIOD = 2'd1;
    localparam logic [1:0] REG_FAULT_PERIOD  = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] STALE_TIMEOUT_RST  = 16'd500;
    localparam logic [CFG_W-1:0] PUBLISH_PERIOD_RST = 16'd50;
    localparam logic [CFG_W-1:0] FAULT_PERIOD_RST   = 16'd200;

    // Fault codes
    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_TIMEOUT  = 2'd1;
    localparam logic [1:0] FAULT_CHECKSUM = 2'd2;

    // What a finished frame hands to the publisher
    typedef struct packed {
        logic                           gyro_load;
        logic                           angle_load;
        logic                           sum_fault;
        logic [2:0][GYRO_W-1:0]         gyro;
        logic [2:0][ANGLE_W-1:0]        angle;
    } frame_update_t;

endpackage

FILE: sv/imufrp_parser.sv
// Byte collector: assembles 11-byte frames, checks the sum and scales the axes.
module imufrp_parser
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_en,
    input  logic [7:0]              byte_in,
    output imufrp_pkg::frame_update_t update
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] type_reg;
    logic [7:0] type_next;
    logic [7:0] payload_reg [imufrp_pkg::PAYLOAD_LEN];

    logic       idle_skip;
    logic       at_check;

    logic [2:0][imufrp_pkg::GYRO_W-1:0]  gyro_lane;
    logic [2:0][imufrp_pkg::ANGLE_W-1:0] angle_lane;
    logic                                gyro_load;
    logic                                angle_load;
    logic                                sum_fault;

    assign idle_skip = (pos_reg == 4'd0) && (byte_in != imufrp_pkg::HDR_BYTE);
    assign at_check  = (pos_reg == imufrp_pkg::FRAME_LAST);

    // Position, running sum and type byte
    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        type_next = type_reg;
        if (byte_en && !idle_skip)
        begin
            if (at_check)
            begin
                pos_next = 4'd0;
            end
            else
            begin
                sum_next = ((pos_reg == 4'd0) ? 8'd0 : sum_reg) + byte_in;
                if (pos_reg == 4'd1)
                begin
                    type_next = byte_in;
                end
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            type_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            type_reg <= type_next;
        end
    end

    // Payload bytes, positions 2 to 7
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < imufrp_pkg::PAYLOAD_LEN; k++)
        begin
            if (byte_en && (pos_reg == 4'(k + 2)))
            begin
                payload_reg[k] <= byte_in;
            end
        end
    end

    // Axis scaling, one lane per axis
    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        logic signed [15:0]                    raw;
        logic signed [imufrp_pkg::PROD_W-1:0]  gyro_prod;
        logic signed [imufrp_pkg::PROD_W-1:0]  angle_prod;
        logic signed [imufrp_pkg::PROD_W-1:0]  gyro_adj;
        logic signed [imufrp_pkg::PROD_W-1:0]  angle_adj;
        logic signed [imufrp_pkg::PROD_W-1:0]  gyro_q;
        logic signed [imufrp_pkg::PROD_W-1:0]  angle_q;

        assign raw        = {payload_reg[2*k+1], payload_reg[2*k]};
        assign gyro_prod  = imufrp_pkg::PROD_W'(raw) * imufrp_pkg::GYRO_SCALE;
        assign angle_prod = imufrp_pkg::PROD_W'(raw) * imufrp_pkg::ANGLE_SCALE;
        // bias negatives so the arithmetic shift truncates toward zero
        assign gyro_adj   = gyro_prod + (gyro_prod[imufrp_pkg::PROD_W-1] ?
                                         imufrp_pkg::ROUND_BIAS : '0);
        assign angle_adj  = angle_prod + (angle_prod[imufrp_pkg::PROD_W-1] ?
                                          imufrp_pkg::ROUND_BIAS : '0);
        assign gyro_q     = gyro_adj >>> imufrp_pkg::SCALE_SHIFT;
        assign angle_q    = angle_adj >>> imufrp_pkg::SCALE_SHIFT;
        assign gyro_lane[k]  = gyro_q[imufrp_pkg::GYRO_W-1:0];
        assign angle_lane[k] = angle_q[imufrp_pkg::ANGLE_W-1:0];
    end

    // Frame completion
    always_comb
    begin
        gyro_load  = 1'b0;
        angle_load = 1'b0;
        sum_fault  = 1'b0;
        if (byte_en && at_check)
        begin
            if (sum_reg != byte_in)
            begin
                sum_fault = 1'b1;
            end
            else
            begin
                gyro_load  = (type_reg == imufrp_pkg::TYPE_GYRO);
                angle_load = (type_reg == imufrp_pkg::TYPE_ANGLE);
            end
        end
    end

    assign update = {gyro_load, angle_load, sum_fault, gyro_lane, angle_lane};

endmodule

FILE: sv/imu_frame_receiver_publisher.sv
// Top level: input register, reading ages, publish decision and output register.
//
// Accepts one word per clock: tuser = 0 carries a received byte in tdata[7:0],
// tuser = 1 is a one-millisecond tick. A tick that publishes puts one sample
// word on the master side by way of the input register and then the state
// update that loads the output register; bytes never produce a word. Sustained
// rate is one input word per cycle as long as the sink takes samples; while a
// sample waits in the output register, bytes still flow and only a following
// tick is held. Frames are 11 bytes starting with 0x55; gyro (0x52) and angle
// (0x53) frames with a good sum update the readings, a bad sum flags a checksum
// fault that fault samples report until the next valid sample clears it.
// Register writes (index 0 stale timeout, 1 publish period, 2 fault period)
// take effect at once and belong to idle periods.
module imu_frame_receiver_publisher
#(
    parameter int AGE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] cmd
    // published samples
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [15:0] sample_number, [27:16] gyro_x, [39:28] gyro_y,
                                   // [51:40] gyro_z, [60:52] roll_angle,
                                   // [69:61] pitch_angle, [78:70] yaw_deg, [79] zero
    output logic [2:0]  m_tuser,   // [0] sample_valid, [2:1] fault_code
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CMP_W = (AGE_BITS > imufrp_pkg::CFG_W) ? AGE_BITS : imufrp_pkg::CFG_W;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    // Configuration registers
    logic [imufrp_pkg::CFG_W-1:0] stale_timeout_reg;
    logic [imufrp_pkg::CFG_W-1:0] publish_period_reg;
    logic [imufrp_pkg::CFG_W-1:0] fault_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_timeout_reg  <= imufrp_pkg::STALE_TIMEOUT_RST;
            publish_period_reg <= imufrp_pkg::PUBLISH_PERIOD_RST;
            fault_period_reg   <= imufrp_pkg::FAULT_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                imufrp_pkg::REG_STALE_TIMEOUT:  stale_timeout_reg  <= cfg_data;
                imufrp_pkg::REG_PUBLISH_PERIOD: publish_period_reg <= cfg_data;
                imufrp_pkg::REG_FAULT_PERIOD:   fault_period_reg   <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // Input register
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       byte_go;
    logic       tick_go;

    assign advance  = in_valid_reg &&
                      ((in_cmd_reg == imufrp_pkg::CMD_BYTE) || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign byte_go  = advance && (in_cmd_reg == imufrp_pkg::CMD_BYTE);
    assign tick_go  = advance && (in_cmd_reg == imufrp_pkg::CMD_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // Frame parser
    imufrp_pkg::frame_update_t upd;

    imufrp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_go),
        .byte_in (in_byte_reg),
        .update  (upd)
    );

    // Reading and publish state
    logic [2:0][imufrp_pkg::GYRO_W-1:0]  gyro_axes_reg;
    logic [2:0][imufrp_pkg::ANGLE_W-1:0] angle_axes_reg;
    logic                                gyro_seen_reg;
    logic                                angle_seen_reg;
    logic [AGE_BITS-1:0]                 gyro_age_reg;
    logic [AGE_BITS-1:0]                 angle_age_reg;
    logic [AGE_BITS-1:0]                 publish_age_reg;
    logic                                published_once_reg;
    logic                                checksum_fault_reg;
    logic [imufrp_pkg::COUNT_W-1:0]      sample_count_reg;

    // Tick evaluation on the incremented ages
    logic [AGE_BITS-1:0]              gyro_age_inc;
    logic [AGE_BITS-1:0]              angle_age_inc;
    logic [AGE_BITS-1:0]              publish_age_inc;
    logic                             fresh;
    logic [imufrp_pkg::CFG_W-1:0]     period;
    logic                             publish;

    assign gyro_age_inc    = (gyro_age_reg == AGE_MAX) ? gyro_age_reg
                                                       : gyro_age_reg + AGE_BITS'(1);
    assign angle_age_inc   = (angle_age_reg == AGE_MAX) ? angle_age_reg
                                                        : angle_age_reg + AGE_BITS'(1);
    assign publish_age_inc = (publish_age_reg == AGE_MAX) ? publish_age_reg
                                                          : publish_age_reg + AGE_BITS'(1);
    assign fresh   = gyro_seen_reg && angle_seen_reg &&
                     (CMP_W'(gyro_age_inc) < CMP_W'(stale_timeout_reg)) &&
                     (CMP_W'(angle_age_inc) < CMP_W'(stale_timeout_reg));
    assign period  = fresh ? publish_period_reg : fault_period_reg;
    assign publish = tick_go &&
                     (!published_once_reg || (CMP_W'(publish_age_inc) >= CMP_W'(period)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_axes_reg      <= '0;
            angle_axes_reg     <= '0;
            gyro_seen_reg      <= 1'b0;
            angle_seen_reg     <= 1'b0;
            gyro_age_reg       <= AGE_MAX;
            angle_age_reg      <= AGE_MAX;
            publish_age_reg    <= '0;
            published_once_reg <= 1'b0;
            checksum_fault_reg <= 1'b0;
            sample_count_reg   <= '0;
        end
        else
        begin
            // finished frames
            if (upd.gyro_load)
            begin
                gyro_axes_reg <= upd.gyro;
                gyro_age_reg  <= '0;
                gyro_seen_reg <= 1'b1;
            end
            if (upd.angle_load)
            begin
                angle_axes_reg <= upd.angle;
                angle_age_reg  <= '0;
                angle_seen_reg <= 1'b1;
            end
            if (upd.sum_fault)
            begin
                checksum_fault_reg <= 1'b1;
            end
            // ticks
            if (tick_go)
            begin
                gyro_age_reg  <= gyro_age_inc;
                angle_age_reg <= angle_age_inc;
                if (publish)
                begin
                    publish_age_reg    <= '0;
                    published_once_reg <= 1'b1;
                    sample_count_reg   <= sample_count_reg + imufrp_pkg::COUNT_W'(1);
                    if (fresh)
                    begin
                        checksum_fault_reg <= 1'b0;
                    end
                end
                else
                begin
                    publish_age_reg <= publish_age_inc;
                end
            end
        end
    end

    // Output register
    logic [79:0] out_data_reg;
    logic [2:0]  out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (publish)
        begin
            if (fresh)
            begin
                out_data_reg <= {1'b0,
                                 angle_axes_reg[2], angle_axes_reg[1], angle_axes_reg[0],
                                 gyro_axes_reg[2], gyro_axes_reg[1], gyro_axes_reg[0],
                                 sample_count_reg};
                out_user_reg <= {imufrp_pkg::FAULT_NONE, 1'b1};
            end
            else
            begin
                out_data_reg <= {64'd0, sample_count_reg};
                out_user_reg <= {(checksum_fault_reg ? imufrp_pkg::FAULT_CHECKSUM
                                                     : imufrp_pkg::FAULT_TIMEOUT), 1'b0};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: test/tb.sv
// Testbench for the IMU frame receiver and sample publisher.
`timescale 1ns / 100ps

module tb;

    // One published sample as the block should present it
    typedef struct {
        logic [15:0]                           num;
        logic signed [imufrp_pkg::GYRO_W-1:0]  gx;
        logic signed [imufrp_pkg::GYRO_W-1:0]  gy;
        logic signed [imufrp_pkg::GYRO_W-1:0]  gz;
        logic signed [imufrp_pkg::ANGLE_W-1:0] roll;
        logic signed [imufrp_pkg::ANGLE_W-1:0] pitch;
        logic signed [imufrp_pkg::ANGLE_W-1:0] yaw;
        logic                                  valid;
        logic [1:0]                            fault;
    } imu_sample_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_tuser = 1'b0;    // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;           // [15:0] sample_number, [27:16] gyro_x, [39:28] gyro_y,
                                    // [51:40] gyro_z, [60:52] roll_angle,
                                    // [69:61] pitch_angle, [78:70] yaw_deg, [79] zero
    logic [2:0]  m_tuser;           // [0] sample_valid, [2:1] fault_code
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    // Tracked copy of the block state
    logic [15:0]                            stale_to = imufrp_pkg::STALE_TIMEOUT_RST;
    logic [15:0]                            pub_per = imufrp_pkg::PUBLISH_PERIOD_RST;
    logic [15:0]                            flt_per = imufrp_pkg::FAULT_PERIOD_RST;
    logic [3:0]                             fr_pos = '0;
    logic [7:0]                             fr_sum = '0;
    logic [7:0]                             fr_type = '0;
    logic [5:0][7:0]                        fr_pay = '0;
    logic [2:0][imufrp_pkg::GYRO_W-1:0]     gyro_v = '0;
    logic [2:0][imufrp_pkg::ANGLE_W-1:0]    angle_v = '0;
    logic                                   gyro_ok = 1'b0;
    logic                                   angle_ok = 1'b0;
    logic [15:0]                            gyro_age = 16'hFFFF;
    logic [15:0]                            angle_age = 16'hFFFF;
    logic [15:0]                            pub_age = 16'h0000;
    logic                                   pub_once = 1'b0;
    logic                                   sum_fault = 1'b0;
    logic [15:0]                            sample_cnt = 16'h0000;

    imu_sample_t due_samples[$];
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          tick_pct = 10;
    bit          no_idle = 1'b0;
    int          sink_hold_req = 0;
    int          sink_wait = 0;

    imu_frame_receiver_publisher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Run limit
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(input int zero_pct);
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] a);
        return (a == 16'hFFFF) ? a : a + 16'd1;
    endfunction

    // raw * full / 32768, truncated toward zero
    function automatic int scale_raw(input logic [15:0] raw, input int full);
        int v;
        v = int'($signed(raw));
        return (v * full) / 32768;
    endfunction

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Advance the tracked state by one accepted word, queue any sample it causes
    task automatic imu_track_word(input logic cmd, input logic [7:0] b);
        logic        fresh;
        logic [15:0] period;
        imu_sample_t s;
        int          k;
        if (cmd == imufrp_pkg::CMD_BYTE)
        begin
            if (fr_pos == 4'd0 && b != imufrp_pkg::HDR_BYTE)
                return;
            if (fr_pos == imufrp_pkg::FRAME_LAST)
            begin
                fr_pos = 4'd0;
                if (fr_sum != b)
                begin
                    sum_fault = 1'b1;
                end
                else if (fr_type == imufrp_pkg::TYPE_GYRO)
                begin
                    for (k = 0; k < 3; k++)
                        gyro_v[k] = imufrp_pkg::GYRO_W'(
                            scale_raw({fr_pay[2*k+1], fr_pay[2*k]},
                                      int'(imufrp_pkg::GYRO_SCALE)));
                    gyro_age = 16'd0;
                    gyro_ok = 1'b1;
                end
                else if (fr_type == imufrp_pkg::TYPE_ANGLE)
                begin
                    for (k = 0; k < 3; k++)
                        angle_v[k] = imufrp_pkg::ANGLE_W'(
                            scale_raw({fr_pay[2*k+1], fr_pay[2*k]},
                                      int'(imufrp_pkg::ANGLE_SCALE)));
                    angle_age = 16'd0;
                    angle_ok = 1'b1;
                end
                return;
            end
            if (fr_pos == 4'd0)
                fr_sum = 8'd0;
            else if (fr_pos == 4'd1)
                fr_type = b;
            else if (fr_pos < 4'd8)
                fr_pay[3'(fr_pos - 4'd2)] = b;
            fr_sum = fr_sum + b;
            fr_pos = fr_pos + 4'd1;
            return;
        end

        // tick: age first, then decide from the new ages
        gyro_age = sat_inc(gyro_age);
        angle_age = sat_inc(angle_age);
        pub_age = sat_inc(pub_age);
        fresh = gyro_ok && angle_ok && gyro_age < stale_to && angle_age < stale_to;
        period = fresh ? pub_per : flt_per;
        if (pub_once && pub_age < period)
            return;
        s.num = sample_cnt;
        sample_cnt = sample_cnt + 16'd1;
        if (fresh)
        begin
            s.gx = gyro_v[0];
            s.gy = gyro_v[1];
            s.gz = gyro_v[2];
            s.roll = angle_v[0];
            s.pitch = angle_v[1];
            s.yaw = angle_v[2];
            s.valid = 1'b1;
            s.fault = imufrp_pkg::FAULT_NONE;
            sum_fault = 1'b0;
        end
        else
        begin
            s.gx = '0;
            s.gy = '0;
            s.gz = '0;
            s.roll = '0;
            s.pitch = '0;
            s.yaw = '0;
            s.valid = 1'b0;
            s.fault = sum_fault ? imufrp_pkg::FAULT_CHECKSUM : imufrp_pkg::FAULT_TIMEOUT;
        end
        pub_age = 16'd0;
        pub_once = 1'b1;
        due_samples.push_back(s);
    endtask

    // Offer one word, wait for the handshake, then track it
    task automatic send_word(input logic cmd, input logic [7:0] b);
        int gap;
        gap = pick_gap(60);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        imu_track_word(cmd, b);
    endtask

    // One 11-byte frame, ticks sprinkled in between its bytes
    task automatic send_frame(input logic [7:0] kind, input logic [2:0][15:0] axes,
                              input bit bad);
        logic [10:0][7:0] fb;
        logic [7:0]       sum;
        int               i;
        fb[0] = imufrp_pkg::HDR_BYTE;
        fb[1] = kind;
        for (i = 0; i < 3; i++)
        begin
            fb[2 + 2*i] = axes[i][7:0];
            fb[3 + 2*i] = axes[i][15:8];
        end
        fb[8] = 8'($urandom);
        fb[9] = 8'($urandom);
        sum = 8'd0;
        for (i = 0; i < 10; i++)
            sum = sum + fb[i];
        fb[10] = bad ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        for (i = 0; i < 11; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                send_word(imufrp_pkg::CMD_TICK, 8'($urandom));
            send_word(imufrp_pkg::CMD_BYTE, fb[i]);
        end
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_word(imufrp_pkg::CMD_TICK, 8'($urandom));
    endtask

    // Quiet the input and let the block drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (due_samples.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            imufrp_pkg::REG_STALE_TIMEOUT:  stale_to = val;
            imufrp_pkg::REG_PUBLISH_PERIOD: pub_per = val;
            imufrp_pkg::REG_FAULT_PERIOD:   flt_per = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] stale, input logic [15:0] pub,
                              input logic [15:0] flt);
        wait_idle();
        write_reg(imufrp_pkg::REG_STALE_TIMEOUT, stale);
        write_reg(imufrp_pkg::REG_PUBLISH_PERIOD, pub);
        write_reg(imufrp_pkg::REG_FAULT_PERIOD, flt);
    endtask

    // Reset values: first tick publishes, axis extremes, valid after 50 ticks
    task automatic test_reset_defaults();
        send_word(imufrp_pkg::CMD_BYTE, 8'h00);
        send_word(imufrp_pkg::CMD_BYTE, 8'hFF);
        send_word(imufrp_pkg::CMD_TICK, 8'hFF);
        tick_pct = 0;
        send_frame(imufrp_pkg::TYPE_GYRO, {16'hFFFF, 16'h7FFF, 16'h8000}, 1'b0);
        send_frame(imufrp_pkg::TYPE_ANGLE, {16'hFFFF, 16'h8000, 16'h7FFF}, 1'b0);
        send_ticks(51);
        tick_pct = 10;
    endtask

    // Bad sum reported as checksum fault, unknown type ignored, valid clears it
    task automatic test_checksum_fault();
        set_config(16'd4, 16'd2, 16'd3);
        send_frame(imufrp_pkg::TYPE_GYRO, {16'h1234, 16'h0000, 16'hFFFF}, 1'b1);
        send_ticks(6);
        send_frame(8'h51, {16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0);
        send_ticks(3);
        send_frame(imufrp_pkg::TYPE_GYRO, {16'hC000, 16'h4000, 16'h0001}, 1'b0);
        send_frame(imufrp_pkg::TYPE_ANGLE, {16'h8001, 16'h0100, 16'hFF00}, 1'b0);
        send_ticks(4);
        send_ticks(8);
    endtask

    // Sink holds off while the source keeps pushing
    task automatic test_backpressure();
        set_config(16'd30, 16'd1, 16'd1);
        no_idle = 1'b1;
        sink_hold_req = 300;
        send_frame(imufrp_pkg::TYPE_GYRO, {pick_axis(), pick_axis(), pick_axis()}, 1'b0);
        send_frame(imufrp_pkg::TYPE_ANGLE, {pick_axis(), pick_axis(), pick_axis()}, 1'b0);
        send_ticks(60);
        no_idle = 1'b0;
    endtask

    // Largest register values: none of the ticks publishes
    task automatic test_long_periods();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_frame(imufrp_pkg::TYPE_GYRO, {pick_axis(), pick_axis(), pick_axis()}, 1'b0);
        send_frame(imufrp_pkg::TYPE_ANGLE, {pick_axis(), pick_axis(), pick_axis()}, 1'b0);
        no_idle = 1'b1;
        tick_pct = 0;
        send_ticks(40);
        no_idle = 1'b0;
        tick_pct = 10;
    endtask

    // One random burst: mostly good frames, some broken ones, noise and ticks
    task automatic send_random_burst();
        logic [2:0][15:0] ax;
        int               r;
        ax = {pick_axis(), pick_axis(), pick_axis()};
        r = $urandom_range(0, 99);
        if (r < 35)
            send_frame(imufrp_pkg::TYPE_GYRO, ax, 1'b0);
        else if (r < 70)
            send_frame(imufrp_pkg::TYPE_ANGLE, ax, 1'b0);
        else if (r < 78)
            send_frame($urandom_range(0, 1) ? imufrp_pkg::TYPE_GYRO : imufrp_pkg::TYPE_ANGLE,
                       ax, 1'b1);
        else if (r < 84)
            send_frame(8'($urandom), ax, 1'b0);
        else if (r < 92)
            repeat ($urandom_range(1, 4)) send_word(imufrp_pkg::CMD_BYTE, 8'($urandom));
        else
            send_ticks($urandom_range(1, 8));
    endtask

    task automatic test_random();
        int phase;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_config(16'($urandom_range(8, 40)), 16'($urandom_range(1, 4)),
                              16'($urandom_range(1, 6)));
                1: set_config(16'd1, 16'hFFFF, 16'd1);
                2: set_config(16'hFFFF, 16'd1, 16'hFFFF);
                default: set_config(16'($urandom_range(5, 60)), 16'($urandom_range(1, 8)),
                                    16'($urandom_range(1, 10)));
            endcase
            no_idle = (phase == 2);
            words_sent = 0;
            while (words_sent < 160)
                send_random_burst();
            no_idle = 1'b0;
        end
    endtask

    // Sample sink with random stalls and a requested long hold-off
    always @(posedge clk)
    begin
        if (sink_hold_req > 0)
        begin
            sink_wait = sink_hold_req;
            sink_hold_req = 0;
        end
        if (sink_wait > 0)
        begin
            m_tready <= 1'b0;
            sink_wait--;
        end
        else
        begin
            m_tready <= 1'b1;
            sink_wait = pick_gap(80);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 50)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Compare each delivered sample with the oldest one due
    always @(posedge clk)
    begin : sample_check
        imu_sample_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_samples.size() == 0)
            begin
                report_mismatch("unexpected sample_number", int'(m_tdata[15:0]), -1);
            end
            else
            begin
                want = due_samples.pop_front();
                check_field("sample_number", int'(m_tdata[15:0]), int'(want.num));
                check_field("gyro_x", int'($signed(m_tdata[27:16])), int'(want.gx));
                check_field("gyro_y", int'($signed(m_tdata[39:28])), int'(want.gy));
                check_field("gyro_z", int'($signed(m_tdata[51:40])), int'(want.gz));
                check_field("roll_angle", int'($signed(m_tdata[60:52])), int'(want.roll));
                check_field("pitch_angle", int'($signed(m_tdata[69:61])), int'(want.pitch));
                check_field("yaw_deg", int'($signed(m_tdata[78:70])), int'(want.yaw));
                check_field("tdata pad", int'(m_tdata[79]), 0);
                check_field("sample_valid", int'(m_tuser[0]), int'(want.valid));
                check_field("fault_code", int'(m_tuser[2:1]), int'(want.fault));
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_checksum_fault();
        test_backpressure();
        test_long_periods();
        test_random();
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && due_samples.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
